@@ rtl/core/sha256_stream_hash_macros.svh @@
// Assertion macros for the streaming SHA-256 block.
`ifndef SHA256_STREAM_HASH_MACROS_SVH
`define SHA256_STREAM_HASH_MACROS_SVH
// implication checked at every clock edge outside reset
`define SHA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication checked outside reset
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ rtl/core/sha_pkg.sv @@
// Shared types, constants and functions of the streaming SHA-256 block.
package sha_pkg;
   localparam int HashWords = 8;
   localparam int BlockWords = 16;
   localparam int Rounds = 64;
   localparam int SchedRounds = 48;
   localparam int PadLimit = 55;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       start_of_message;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic clear;       // reload initial hash, clear block and counters
      logic put_byte;    // write byte into block, count it
      logic put_pad;     // write 0x80 pad byte
      logic clear_block; // zero block words and fill
      logic put_length;  // write bit length into last two words
      logic load_vars;   // copy hash into working variables
      logic do_round;    // run one round
      logic add_hash;    // fold working variables into hash
      logic shift_out;   // rotate hash words for output
   } cmd_type;

   typedef struct packed {
      logic       block_full; // 64 bytes collected
      logic       pad_over;   // fill after pad exceeds limit
      logic       last_round;
   } sts_type;

   localparam logic [31:0] HashInit [HashWords] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   function automatic logic [31:0] round_k(input logic [5:0] r);
      logic [31:0] k [Rounds];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
         32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
         32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
         32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
         32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
         32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[r];
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction
endpackage

@@ rtl/core/sha_datapath.sv @@
// Block buffer, message schedule, round logic and hash registers.
module sha_datapath (
   input  logic             clock,
   input  sha_pkg::cmd_type cmd,
   input  logic [7:0]       data_byte,
   output sha_pkg::sts_type sts,
   output logic [31:0]      hash_head
);
   import sha_pkg::*;

   logic [31:0] hash_ff [HashWords];
   logic [31:0] blk_ff [BlockWords];
   logic [31:0] v_ff [HashWords];
   logic [6:0]  fill_ff;
   logic [31:0] total_ff;
   logic [5:0]  round_ff;

   logic [5:0]  pos;
   logic [31:0] w, x1, x14, x9, g0, g1, sched, s0, s1, ch, maj, t1, t2;
   logic [7:0]  wbyte;
   logic [31:0] bmask;

   assign pos   = fill_ff[5:0];
   assign wbyte = cmd.put_pad ? 8'h80 : data_byte;
   assign bmask = {24'd0, wbyte} << (5'd8 * (5'd3 - {3'd0, pos[1:0]}));

   assign w   = blk_ff[0];
   assign x1  = blk_ff[1];
   assign x9  = blk_ff[9];
   assign x14 = blk_ff[14];
   assign g0  = rotr(x1, 7) ^ rotr(x1, 18) ^ (x1 >> 3);
   assign g1  = rotr(x14, 17) ^ rotr(x14, 19) ^ (x14 >> 10);
   assign sched = w + g0 + x9 + g1;
   assign s0  = rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22);
   assign maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign s1  = rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25);
   assign ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign t2  = s0 + maj;
   assign t1  = v_ff[7] + s1 + ch + round_k(round_ff) + w;

   assign sts.block_full = fill_ff[6];
   assign sts.pad_over   = pos > 6'(PadLimit);
   assign sts.last_round = round_ff == 6'(Rounds - 1);
   assign hash_head      = hash_ff[0];

   // window is kept rotated: blk_ff[0] is always w[r]
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         for (int i = 0; i < HashWords; i++) hash_ff[i] <= HashInit[i];
         for (int i = 0; i < BlockWords; i++) blk_ff[i] <= '0;
         fill_ff  <= '0;
         total_ff <= '0;
      end else if (cmd.clear_block) begin
         for (int i = 0; i < BlockWords; i++) blk_ff[i] <= '0;
         fill_ff <= '0;
      end else if (cmd.put_byte || cmd.put_pad) begin
         blk_ff[pos[5:2]] <= blk_ff[pos[5:2]] | bmask;
         if (cmd.put_byte) begin
            fill_ff  <= fill_ff + 7'd1;
            total_ff <= total_ff + 32'd1;
         end
      end else if (cmd.put_length) begin
         blk_ff[14] <= {29'd0, total_ff[31:29]};
         blk_ff[15] <= {total_ff[28:0], 3'd0};
      end else if (cmd.load_vars) begin
         for (int i = 0; i < HashWords; i++) v_ff[i] <= hash_ff[i];
         round_ff <= '0;
      end else if (cmd.do_round) begin
         for (int i = 0; i < BlockWords - 1; i++) blk_ff[i] <= blk_ff[i + 1];
         blk_ff[BlockWords - 1] <= (round_ff < 6'(SchedRounds)) ? sched : w;
         for (int i = 1; i < HashWords; i++) v_ff[i] <= v_ff[i - 1];
         v_ff[4]  <= v_ff[3] + t1;
         v_ff[0]  <= t1 + t2;
         round_ff <= round_ff + 6'd1;
      end else if (cmd.add_hash) begin
         for (int i = 0; i < HashWords; i++) hash_ff[i] <= hash_ff[i] + v_ff[i];
      end else if (cmd.shift_out) begin
         for (int i = 0; i < HashWords - 1; i++) hash_ff[i] <= hash_ff[i + 1];
         hash_ff[HashWords - 1] <= hash_ff[0];
      end
   end
endmodule

@@ rtl/core/sha_control.sv @@
// Sequencer for byte loading, padding, compression and digest output.
module sha_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sha_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [2:0]       rsp_index,
   output sha_pkg::cmd_type cmd,
   input  sha_pkg::sts_type sts
);
   import sha_pkg::*;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_BYTE, S_CHECK, S_LOAD, S_ROUND, S_ADD, S_CLRB,
      S_PAD, S_PADCHK, S_LEN, S_OUT, S_DONE
   } state_type;

   state_type   state_ff, state_in;
   logic        fin_ff, fin_in;   // finishing a message
   logic [1:0]  phase_ff, phase_in; // 0 data block, 1 pad overflow, 2 final block
   logic [2:0]  idx_ff, idx_in;
   logic        byte_ff, byte_in;
   logic        accept;

   assign req_ready = state_ff == S_IDLE;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = state_ff == S_OUT;
   assign rsp_index = idx_ff;

   always_comb begin
      state_in = state_ff;
      fin_in   = fin_ff;
      phase_in = phase_ff;
      idx_in   = idx_ff;
      byte_in  = byte_ff;
      cmd      = '0;
      case (state_ff)
         S_INIT: begin
            cmd.clear = 1'b1;
            state_in  = S_IDLE;
         end
         S_IDLE: if (accept) begin
            cmd.clear = req_data.start_of_message;
            fin_in    = req_data.end_of_message;
            byte_in   = req_data.byte_present;
            state_in  = S_BYTE;
         end
         S_BYTE: begin
            cmd.put_byte = byte_ff;
            state_in     = S_CHECK;
         end
         S_CHECK: begin
            phase_in = 2'd0;
            if (sts.block_full) state_in = S_LOAD;
            else if (fin_ff) state_in = S_PAD;
            else state_in = S_IDLE;
         end
         S_PAD: begin
            cmd.put_pad = 1'b1;
            state_in    = S_PADCHK;
         end
         S_PADCHK: begin
            if (sts.pad_over) begin
               phase_in = 2'd1;
               state_in = S_LOAD;
            end else state_in = S_LEN;
         end
         S_LEN: begin
            cmd.put_length = 1'b1;
            phase_in       = 2'd2;
            state_in       = S_LOAD;
         end
         S_LOAD: begin
            cmd.load_vars = 1'b1;
            state_in      = S_ROUND;
         end
         S_ROUND: begin
            cmd.do_round = 1'b1;
            if (sts.last_round) state_in = S_ADD;
         end
         S_ADD: begin
            cmd.add_hash = 1'b1;
            if (phase_ff == 2'd2) begin
               idx_in   = '0;
               state_in = S_OUT;
            end else state_in = S_CLRB;
         end
         S_CLRB: begin
            cmd.clear_block = 1'b1;
            if (phase_ff == 2'd1) state_in = S_LEN;
            else if (fin_ff) state_in = S_PAD;
            else state_in = S_IDLE;
         end
         S_OUT: if (rsp_ready) begin
            cmd.shift_out = 1'b1;
            idx_in        = idx_ff + 3'd1;
            if (idx_ff == 3'(HashWords - 1)) state_in = S_DONE;
         end
         S_DONE: begin
            cmd.clear = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         fin_ff   <= 1'b0;
         phase_ff <= '0;
         idx_ff   <= '0;
         byte_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         byte_ff  <= byte_in;
      end
   end
endmodule

@@ rtl/core/sha256_stream_hash.sv @@
// Top level of the streaming SHA-256 hasher.
// Streaming SHA-256: at most one message byte per req transfer, packed big-endian
// into a 64-byte block. A byte that does not fill the block passes through the byte
// and check states before ready returns; the byte that fills it adds the 64-round
// compression (one round per cycle in the shared round unit) with load, add and
// block clear.
// end_of_message pads, compresses one or two further blocks, then presents the
// eight digest words as rsp transfers, word 0 first, and clears for the next
// message. No req transfer is taken while a digest is being delivered.
// After reset the init state loads the initial hash before the first transfer.
module sha256_stream_hash (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sha_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sha_pkg::rsp_type rsp_data
);
   import sha_pkg::*;

   cmd_type     cmd;
   sts_type     sts;
   logic [31:0] hash_head;
   logic [2:0]  idx;

   sha_control u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_index(idx), .cmd, .sts
   );

   // data byte captured at the transfer, written into the block in the next cycle
   logic [7:0] byte_ff;
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) byte_ff <= req_data.data_byte;
   end

   sha_datapath u_dp (
      .clock, .cmd, .data_byte(byte_ff), .sts, .hash_head
   );

   // hash words rotate on each output transfer, so the head is always the word being presented
   assign rsp_data.digest_word = hash_head;
   assign rsp_data.word_index  = idx;
   assign rsp_data.last_word   = idx == 3'(HashWords - 1);
endmodule

@@ rtl/core/sha_checker.sv @@
// Port-level checks of the streaming SHA-256 block, bound to the top level.
`include "sha256_stream_hash_macros.svh"
module sha_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sha_pkg::rsp_type rsp_data
);
   `SHA_ASSERT_IMP(a_no_overlap, clock, reset, rsp_valid, !req_ready, "ready during digest")
   `SHA_ASSERT_IMP(a_last_idx, clock, reset, rsp_valid, rsp_data.last_word == (rsp_data.word_index == 3'd7), "last flag mismatch")
   `SHA_ASSERT_NEXT(a_idx_step, clock, reset, rsp_valid && rsp_ready && !rsp_data.last_word, rsp_valid && rsp_data.word_index == $past(rsp_data.word_index) + 3'd1, "word order")
   `SHA_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp not held")
endmodule

bind sha256_stream_hash sha_checker u_chk (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_data
);

@@ tb/sv/sha256_stream_hash_tb.sv @@
// Self-checking testbench for the streaming SHA-256 hasher.
`timescale 1ns / 1ps

module sha256_stream_hash_tb;
   import sha_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   sha256_stream_hash dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   // Round constants, kept locally so the predictor stands on its own.
   localparam logic [31:0] RoundConst [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   // Predictor state: running hash, message block, fill and byte count.
   logic [31:0] run_hash [8];
   logic [31:0] msg_block [16];
   logic [6:0]  msg_fill;
   logic [31:0] msg_bytes;

   req_type item_queue [$];   // items waiting to be driven
   rsp_type digest_queue [$]; // digest words still owed by the block
   int      mismatches = 0;
   int      words_seen = 0;
   int      digests_done = 0;
   bit      stimulus_done = 1'b0;
   bit      calm = 1'b0;      // no idling in the final stretch
   bit      drain_wait = 1'b0; // sender waits for every digest word
   int      hold_cycles = 0;  // long receiver hold-off, counted below
   int      snd_gap = 0, rcv_gap = 0;

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic fresh_message();
      run_hash = HashInit;
      foreach (msg_block[i]) msg_block[i] = '0;
      msg_fill  = '0;
      msg_bytes = '0;
   endtask

   // One compression; the schedule rolls through the 16-word window.
   task automatic compress_block();
      logic [31:0] v [8];
      logic [31:0] w, s0, s1, t1, t2;
      v = run_hash;
      for (int r = 0; r < 64; r++) begin
         w = msg_block[r % 16];
         if (r < 48) begin
            s0 = ror(msg_block[(r+1)%16], 7) ^ ror(msg_block[(r+1)%16], 18)
                 ^ (msg_block[(r+1)%16] >> 3);
            s1 = ror(msg_block[(r+14)%16], 17) ^ ror(msg_block[(r+14)%16], 19)
                 ^ (msg_block[(r+14)%16] >> 10);
            msg_block[r%16] = w + s0 + msg_block[(r+9)%16] + s1;
         end
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[r] + w;
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) run_hash[i] += v[i];
   endtask

   task automatic place_byte(input logic [7:0] b);
      logic [5:0] pos;
      pos = msg_fill[5:0];
      msg_block[pos[5:2]] |= 32'(b) << (8 * (3 - pos[1:0]));
   endtask

   // Advance the predictor by one accepted item and queue any digest words.
   task automatic hash_item(input req_type it);
      rsp_type d;
      if (it.start_of_message) fresh_message();
      if (it.byte_present) begin
         place_byte(it.data_byte);
         msg_fill  = msg_fill + 7'd1;
         msg_bytes = msg_bytes + 32'd1;
         if (msg_fill >= 64) begin
            compress_block();
            foreach (msg_block[i]) msg_block[i] = '0;
            msg_fill = '0;
         end
      end
      if (it.end_of_message) begin
         place_byte(8'h80);
         // no room for the length: an extra block goes first
         if (msg_fill[5:0] > PadLimit) begin
            compress_block();
            foreach (msg_block[i]) msg_block[i] = '0;
         end
         msg_block[14] = msg_bytes >> 29;
         msg_block[15] = msg_bytes << 3;
         compress_block();
         for (int k = 0; k < 8; k++) begin
            d.digest_word = run_hash[k];
            d.word_index  = 3'(k);
            d.last_word   = (k == 7);
            digest_queue.push_back(d);
         end
         fresh_message();
      end
   endtask

   task automatic report(input string what, input rsp_type got, input rsp_type want);
      mismatches++;
      $display("MISMATCH %s: got %h/%0d/%0d want %h/%0d/%0d", what,
               got.digest_word, got.word_index, got.last_word,
               want.digest_word, want.word_index, want.last_word);
   endtask

   // Driver: one nonblocking write per signal per edge; predicts on each transfer.
   always @(posedge clock) begin
      bit done_xfer;
      done_xfer = req_valid && req_ready;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (done_xfer) hash_item(req_data);
         if (req_valid && !done_xfer) begin
            // hold valid and payload until taken
         end else if (snd_gap > 0) begin
            snd_gap--;
            req_valid <= 1'b0;
         end else if (drain_wait && digest_queue.size() != 0) begin
            req_valid <= 1'b0;
         end else if (item_queue.size() != 0) begin
            if (!calm && $urandom_range(0, 9) == 0) begin
               snd_gap   = $urandom_range(1, 4) - 1;
               req_valid <= 1'b0;
            end else begin
               req_data  <= item_queue.pop_front();
               req_valid <= 1'b1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: checks each digest transfer against the oldest expected word.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         words_seen++;
         if (digest_queue.size() == 0) begin
            report("unexpected transfer", rsp_data, '0);
         end else begin
            want = digest_queue.pop_front();
            if (rsp_data.digest_word != want.digest_word) report("digest_word", rsp_data, want);
            if (rsp_data.word_index != want.word_index) report("word_index", rsp_data, want);
            if (rsp_data.last_word != want.last_word) report("last_word", rsp_data, want);
            if (want.last_word) digests_done++;
         end
      end
      // Receiver: a counted hold-off, random bursts of stall, or always ready.
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_ready <= 1'b0;
      end else if (rcv_gap > 0) begin
         rcv_gap--;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rcv_gap   = $urandom_range(1, 4) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic req_type mk(input logic [7:0] b, input bit p, input bit s, input bit e);
      req_type r;
      r.data_byte = b; r.byte_present = p; r.start_of_message = s; r.end_of_message = e;
      return r;
   endfunction

   // Queues one message of n bytes with random content and optional start flag.
   task automatic add_message(input int n, input bit with_start);
      for (int i = 0; i < n; i++)
         item_queue.push_back(mk(8'($urandom), 1'b1, with_start && i == 0,
                                 i == n - 1));
   endtask

   // sampled away from the driving edge, after its updates have settled
   task automatic wait_drained();
      while (item_queue.size() != 0 || req_valid || digest_queue.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      int n;
      fresh_message();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty message, start+end on one byte, extremes, bare end.
      item_queue.push_back(mk(8'h00, 1'b0, 1'b1, 1'b1));
      item_queue.push_back(mk(8'hff, 1'b1, 1'b1, 1'b1));
      item_queue.push_back(mk(8'h00, 1'b1, 1'b0, 1'b1)); // no start after digest
      item_queue.push_back(mk(8'h61, 1'b1, 1'b1, 1'b0));
      item_queue.push_back(mk(8'h62, 1'b1, 1'b0, 1'b0));
      item_queue.push_back(mk(8'h00, 1'b0, 1'b0, 1'b0)); // empty item mid-message
      item_queue.push_back(mk(8'h63, 1'b1, 1'b0, 1'b0));
      item_queue.push_back(mk(8'h00, 1'b0, 1'b0, 1'b1)); // end carried alone
      item_queue.push_back(mk(8'h5a, 1'b1, 1'b1, 1'b0));
      item_queue.push_back(mk(8'ha5, 1'b1, 1'b1, 1'b1)); // start discards a partial one
      wait_drained();

      // Pad boundaries: 55 fits the length, 56 needs an extra block, 70 spans two.
      add_message(55, 1'b1);
      add_message(56, 1'b1);
      add_message(70, 1'b0);
      // Block stays full of outstanding words: receiver holds off for a long stretch.
      hold_cycles = 300;
      add_message(3, 1'b1);
      add_message(2, 1'b1);
      add_message(1, 1'b1);
      wait_drained();

      // Random short messages.
      for (int m = 0; m < 6; m++) begin
         n = $urandom_range(1, 5);
         if ($urandom_range(0, 9) == 0) begin
            item_queue.push_back(mk(8'($urandom), 1'($urandom_range(0, 1)), 1'b1,
                                    1'($urandom_range(0, 1))));
         end
         add_message(n, $urandom_range(0, 3) != 0);
         if ($urandom_range(0, 4) == 0)
            item_queue.push_back(mk(8'($urandom), 1'b0, 1'b0, 1'b0));
         if (m == 3) begin
            // sender pauses here until every digest word is back
            drain_wait = 1'b1;
            wait_drained();
            drain_wait = 1'b0;
         end
      end
      wait_drained();
      calm = 1'b1;
      add_message(8, 1'b1);
      add_message(4, 1'b1);
      wait_drained();
      stimulus_done = 1'b1;
      repeat (200) @(posedge clock);

      $display("Covered %0d digests (%0d words): empty, pad-boundary and multi-block messages,",
               digests_done, words_seen);
      $display("start/end combinations, empty items and long output back-pressure.");
      if (mismatches == 0 && digest_queue.size() == 0) begin
         $display("sha256_stream_hash_tb: clean");
      end else begin
         $display("sha256_stream_hash_tb: errors");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Timeout with %0d words outstanding", digest_queue.size());
      $display("sha256_stream_hash_tb: errors");
      $finish;
   end

endmodule

@@ sha256_stream_hash.f @@
+incdir+rtl/core
rtl/core/sha_pkg.sv
rtl/core/sha_datapath.sv
rtl/core/sha_control.sv
rtl/core/sha256_stream_hash.sv
rtl/core/sha_checker.sv
tb/sv/sha256_stream_hash_tb.sv
